@@ rtl/lmcr_pkg.sv @@
// lmcr_pkg: shared types and constants for the led matrix column refresh unit
// no dependencies; used by lmcr_seq, lmcr_skid and the top level
package lmcr_pkg;

   localparam int BYTE_W      = 8;
   localparam int STORE_DEPTH = 32;
   localparam int STORE_AW    = 5;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_DONE    = 2'd1,
      OP_WRITE   = 2'd2,
      OP_REFRESH = 2'd3
   } opcode_type;

   typedef struct packed {
      logic              ms_event;
      logic              send_valid;
      logic [BYTE_W-1:0] send_byte;
      logic              led_enable;
      logic              preload_pulse;
      logic              load_pulse;
   } result_type;

endpackage

@@ rtl/lmcr_seq.sv @@
// lmcr_seq: refresh sequencer state, pattern store and per-event result logic
// depends on lmcr_pkg
module lmcr_seq #(
   parameter int BLOCKS  = 4,
   parameter int COLUMNS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [1:0]                      opcode,
   input  logic [lmcr_pkg::STORE_AW-1:0]   pattern_addr,
   input  logic [lmcr_pkg::BYTE_W-1:0]     pattern_data,
   output lmcr_pkg::result_type            result
);

   localparam int CNT_W = $clog2(BLOCKS + 2);
   localparam int COL_W = $clog2(COLUMNS);
   localparam int AW    = lmcr_pkg::STORE_AW;
   localparam int BW    = lmcr_pkg::BYTE_W;

   logic [BW-1:0]    store_ff [lmcr_pkg::STORE_DEPTH];
   logic             pending_ff, pending_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [COL_W-1:0] column_ff, column_in;
   logic             burst_ff, burst_in;
   logic             lit_ff, lit_in;

   logic [CNT_W-1:0] count_inc;
   logic [CNT_W-1:0] read_block;
   logic [AW-1:0]    read_idx;
   logic [BW-1:0]    read_byte;

   assign count_inc  = count_ff + CNT_W'(1);
   assign read_block = (lmcr_pkg::opcode_type'(opcode) == lmcr_pkg::OP_TICK) ?
                       '0 : count_inc;
   // index wraps modulo the store depth
   assign read_idx   = AW'(int'(column_ff) + int'(read_block) * COLUMNS);
   assign read_byte  = store_ff[read_idx];

   always_comb begin
      pending_in = pending_ff;
      count_in   = count_ff;
      column_in  = column_ff;
      burst_in   = burst_ff;
      lit_in     = lit_ff;
      result     = '0;
      case (lmcr_pkg::opcode_type'(opcode))
         lmcr_pkg::OP_TICK: begin
            result.ms_event = 1'b1;
            if (pending_ff) begin
               pending_in           = 1'b0;
               lit_in               = 1'b0;
               count_in             = '0;
               burst_in             = 1'b1;
               result.preload_pulse = 1'b1;
               result.send_valid    = 1'b1;
               result.send_byte     = read_byte;
            end
         end
         lmcr_pkg::OP_DONE: begin
            if (burst_ff) begin
               count_in = count_inc;
               if (count_inc < CNT_W'(BLOCKS)) begin
                  result.send_valid = 1'b1;
                  result.send_byte  = read_byte;
               end else if (count_inc == CNT_W'(BLOCKS)) begin
                  result.send_valid = 1'b1;
                  result.send_byte  = BW'(column_ff);
               end else begin
                  column_in         = (column_ff == COL_W'(COLUMNS - 1)) ?
                                      '0 : column_ff + COL_W'(1);
                  lit_in            = 1'b1;
                  pending_in        = 1'b1;
                  burst_in          = 1'b0;
                  count_in          = '0;
                  result.load_pulse = 1'b1;
               end
            end
         end
         lmcr_pkg::OP_REFRESH: begin
            pending_in = 1'b1;
         end
         default: begin
         end
      endcase
      result.led_enable = lit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         count_ff   <= '0;
         column_ff  <= '0;
         burst_ff   <= 1'b0;
         lit_ff     <= 1'b0;
         for (int i = 0; i < lmcr_pkg::STORE_DEPTH; i++) begin
            store_ff[i] <= '0;
         end
      end else if (accept) begin
         pending_ff <= pending_in;
         count_ff   <= count_in;
         column_ff  <= column_in;
         burst_ff   <= burst_in;
         lit_ff     <= lit_in;
         if (lmcr_pkg::opcode_type'(opcode) == lmcr_pkg::OP_WRITE) begin
            store_ff[pattern_addr] <= pattern_data;
         end
      end
   end

endmodule

@@ rtl/lmcr_skid.sv @@
// lmcr_skid: output register plus skid stage for result transactions
// depends on lmcr_pkg
module lmcr_skid (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  lmcr_pkg::result_type  in_data,
   output logic                  out_valid,
   input  logic                  out_stall,
   output lmcr_pkg::result_type  out_data
);

   logic                 main_valid_ff;
   logic                 skid_valid_ff;
   lmcr_pkg::result_type main_ff;
   lmcr_pkg::result_type skid_ff;
   logic                 take;
   logic                 accept;

   assign in_stall  = skid_valid_ff;
   assign accept    = in_valid & ~skid_valid_ff;
   assign take      = main_valid_ff & ~out_stall;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            main_ff       <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!main_valid_ff || take) begin
            main_ff       <= in_data;
            main_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= in_data;
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         main_valid_ff <= 1'b0;
      end
   end

endmodule

@@ rtl/led_matrix_column_refresh_unit.sv @@
// result: registered in the output buffer when its request is accepted
// throughput: one request per cycle while req_stall is low, with a combinational
//   sequencer step and a two-entry buffer (main register plus skid stage)
// reset: synchronous, active high; clears the pattern store, the pending flag,
//   the transfer counter, the column and the led enable, and empties the buffer
module led_matrix_column_refresh_unit #(
   parameter int BLOCKS  = 4,
   parameter int COLUMNS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_opcode,
   input  logic [lmcr_pkg::STORE_AW-1:0] req_pattern_addr,
   input  logic [lmcr_pkg::BYTE_W-1:0]   req_pattern_data,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_ms_event,
   output logic                          rsp_send_valid,
   output logic [lmcr_pkg::BYTE_W-1:0]   rsp_send_byte,
   output logic                          rsp_led_enable,
   output logic                          rsp_preload_pulse,
   output logic                          rsp_load_pulse
);

   // request transaction completes when valid is high and we are not stalling
   logic                 req_accept;
   lmcr_pkg::result_type step_result;
   lmcr_pkg::result_type rsp_result;

   assign req_accept = req_valid & ~req_stall;

   // sequencer: state and pattern store advance on each accepted transaction,
   // the result for that transaction is formed in the same cycle
   lmcr_seq #(
      .BLOCKS  (BLOCKS),
      .COLUMNS (COLUMNS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .opcode       (req_opcode),
      .pattern_addr (req_pattern_addr),
      .pattern_data (req_pattern_data),
      .result       (step_result)
   );

   // output register with skid stage, so a waiting result never blocks intake
   // until a second one piles up behind it
   lmcr_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (step_result),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_result)
   );

   // unpack the result transaction onto its ports
   assign rsp_ms_event      = rsp_result.ms_event;
   assign rsp_send_valid    = rsp_result.send_valid;
   assign rsp_send_byte     = rsp_result.send_byte;
   assign rsp_led_enable    = rsp_result.led_enable;
   assign rsp_preload_pulse = rsp_result.preload_pulse;
   assign rsp_load_pulse    = rsp_result.load_pulse;

endmodule
